>>> hdl/moe_probability_mass_gate_defines.svh
// Assertion macros used by the checker file.
// Each expects clk and rst_n in the scope of its use.
`ifndef MOE_PROBABILITY_MASS_GATE_DEFINES_SVH
`define MOE_PROBABILITY_MASS_GATE_DEFINES_SVH

// Same-cycle implication.
`define MOEPMG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MOEPMG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/moepmg_pkg.sv
package moepmg_pkg;

  localparam int MAX_RANKS_DEF = 64;

  localparam int ID_W     = 12;
  localparam int PROB_W   = 16;
  localparam int THR_W    = 17;
  localparam int COUNT_W  = 7;
  localparam int RANK_W   = 6;
  localparam int DROP_W   = 32;
  localparam int FRAC_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS_THRESHOLD = 2'd0,
    CFG_MIN_KEEP       = 2'd1,
    CFG_USED_COUNT     = 2'd2
  } cfg_index_t;

  localparam logic [THR_W-1:0]   THR_RST      = 17'd0;
  localparam logic [COUNT_W-1:0] MIN_KEEP_RST = 7'd2;
  localparam logic [COUNT_W-1:0] USED_RST     = 7'd8;

  typedef struct packed {
    logic [ID_W-1:0]   expert_id;
    logic [PROB_W-1:0] probability;
    logic              last_of_token;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   kept_id;
    logic [RANK_W-1:0] kept_rank;
    logic              last_kept;
    logic [DROP_W-1:0] dropped_total;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PROB_W-1:0] prob;
  } rank_entry_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_SUM    = 8'b0000_0100,
    ST_MUL    = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_CLAMP  = 8'b0010_0000,
    ST_DROP   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

endpackage

>>> hdl/moepmg_chan_if.sv
interface moepmg_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/moe_probability_mass_gate.sv
// Top-p expert gate. Each input word carries one expert of a token, highest
// probability first; the block stores up to MAX_RANKS of them. The word marked
// last_of_token closes the token: the block sums the first used_count
// probabilities, then walks the ranks again until the running mass reaches
// mass_threshold of that sum (tested exactly as cum * 2^16 >= threshold * sum),
// raises the kept count to min_keep, clamps it to the entries received, and
// streams the kept expert ids in rank order, one output word each, the last one
// flagged by last_kept. Ranks of the used set that are dropped add to a
// saturating 32-bit counter shown on every output word. A zero threshold, or a
// used_count above the entries received, skips gating and streams used_count
// ids, capped at MAX_RANKS; a zero sum streams nothing. Non-final words are
// taken whenever the block is idle. A final word is followed by a busy phase
// (shorter when the target is reached early, stretched by out_ch stalls),
// during which in_ch.ready is low: the rank store has one registered read
// port, walked once to sum, once to scan and once to emit (only to emit when
// gating is skipped), one rank per cycle unless out_ch stalls the emit walk.
// The last kept id may still wait on out_ch while the next token's words are
// accepted. Configuration writes are taken in any cycle.
module moe_probability_mass_gate #(
  parameter int MAX_RANKS = moepmg_pkg::MAX_RANKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  moepmg_chan_if.sink   in_ch,
  moepmg_chan_if.source out_ch,
  moepmg_chan_if.sink   cfg_ch
);

  // Count width holds MAX_RANKS itself; address width indexes the store.
  localparam int CW   = $clog2(MAX_RANKS + 1);
  localparam int AW   = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int CMPW = (CW > moepmg_pkg::COUNT_W) ? CW : moepmg_pkg::COUNT_W;
  localparam int SW   = moepmg_pkg::PROB_W + CW;
  localparam int PW   = moepmg_pkg::THR_W + SW;

  // Configuration registers
  logic [moepmg_pkg::THR_W-1:0]   thr_r;
  logic [moepmg_pkg::COUNT_W-1:0] min_keep_r;
  logic [moepmg_pkg::COUNT_W-1:0] used_cnt_r;

  // Sequencer state
  moepmg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] ld_r, ld_nxt;
  logic          pend_r, pend_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [SW-1:0] cum_r, cum_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [moepmg_pkg::DROP_W-1:0] drop_r, drop_nxt;

  // Output register
  logic                  out_valid_r;
  moepmg_pkg::out_word_t out_word_r;

  // Rank store
  moepmg_pkg::rank_entry_t rank_mem [MAX_RANKS];
  moepmg_pkg::rank_entry_t rd_q;
  logic                    wr_en;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  logic                  in_acc;
  logic                  stored;
  logic [CW-1:0]         used_w;
  logic                  bypass;
  logic [SW-1:0]         cum_add;
  logic                  hit;
  logic                  can_load;
  logic                  load_out;
  logic [CMPW-1:0]       m_raised;
  logic [CW-1:0]         m_clamped;
  logic [CW-1:0]         drop_d;
  logic [moepmg_pkg::DROP_W:0] drop_sum;
  logic [31:0]           rank_w;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == moepmg_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // Config writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= moepmg_pkg::THR_RST;
      min_keep_r <= moepmg_pkg::MIN_KEEP_RST;
      used_cnt_r <= moepmg_pkg::USED_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        moepmg_pkg::CFG_MASS_THRESHOLD: thr_r <= cfg_ch.data.wdata;
        moepmg_pkg::CFG_MIN_KEEP:
          min_keep_r <= cfg_ch.data.wdata[moepmg_pkg::COUNT_W-1:0];
        moepmg_pkg::CFG_USED_COUNT:
          used_cnt_r <= cfg_ch.data.wdata[moepmg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Used count clamped to the store depth.
  assign used_w = (CMPW'(used_cnt_r) > CMPW'(MAX_RANKS)) ? CW'(MAX_RANKS)
                                                           : CW'(used_cnt_r);
  assign bypass = (thr_r == '0) || (used_w == '0) || (used_w > n_r);
  assign stored = (seen_r < CW'(MAX_RANKS));

  // Running mass against threshold * sum, both in Q16 scale.
  assign cum_add = cum_r + SW'(rd_q.prob);
  assign hit     = (PW'({cum_add, {moepmg_pkg::FRAC_W{1'b0}}}) >= prod_r);

  // Kept count: raise to min_keep, then clamp to entries received.
  assign m_raised  = (CMPW'(m_r) < CMPW'(min_keep_r)) ? CMPW'(min_keep_r)
                                                       : CMPW'(m_r);
  assign m_clamped = (m_raised > CMPW'(n_r)) ? n_r : CW'(m_raised);

  assign drop_d   = used_w - m_r;
  assign drop_sum = {1'b0, drop_r} + (moepmg_pkg::DROP_W + 1)'(drop_d);

  assign can_load = pend_r && (!out_valid_r || out_ch.ready);
  assign rd_addr  = iss_r[AW-1:0];
  assign wr_addr  = seen_r[AW-1:0];
  assign rank_w   = 32'(ld_r);

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    iss_nxt   = iss_r;
    ld_nxt    = ld_r;
    pend_nxt  = pend_r;
    sum_nxt   = sum_r;
    cum_nxt   = cum_r;
    prod_nxt  = prod_r;
    drop_nxt  = drop_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      moepmg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (stored) begin
            wr_en    = 1'b1;
            seen_nxt = seen_r + CW'(1);
          end
          if (in_ch.data.last_of_token) begin
            n_nxt     = seen_r + CW'(stored);
            seen_nxt  = '0;
            state_nxt = moepmg_pkg::ST_DECIDE;
          end
        end
      end
      moepmg_pkg::ST_DECIDE: begin
        iss_nxt  = '0;
        ld_nxt   = '0;
        pend_nxt = 1'b0;
        sum_nxt  = '0;
        cum_nxt  = '0;
        if (bypass) begin
          m_nxt     = used_w;
          state_nxt = (used_w == '0) ? moepmg_pkg::ST_IDLE : moepmg_pkg::ST_EMIT;
        end else begin
          state_nxt = moepmg_pkg::ST_SUM;
        end
      end
      moepmg_pkg::ST_SUM: begin
        rd_en    = (iss_r < used_w);
        pend_nxt = rd_en;
        if (rd_en) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (pend_r) begin
          sum_nxt = sum_r + SW'(rd_q.prob);
        end
        if (!rd_en && !pend_r) begin
          iss_nxt   = '0;
          state_nxt = (sum_r == '0) ? moepmg_pkg::ST_IDLE : moepmg_pkg::ST_MUL;
        end
      end
      moepmg_pkg::ST_MUL: begin
        prod_nxt  = PW'(thr_r) * PW'(sum_r);
        state_nxt = moepmg_pkg::ST_SCAN;
      end
      moepmg_pkg::ST_SCAN: begin
        rd_en    = (iss_r < used_w);
        pend_nxt = rd_en;
        if (rd_en) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (pend_r) begin
          cum_nxt = cum_add;
          ld_nxt  = ld_r + CW'(1);
          if (hit) begin
            m_nxt     = ld_r + CW'(1);
            state_nxt = moepmg_pkg::ST_CLAMP;
          end
        end else if (!rd_en) begin
          // threshold never reached: keep the whole used set
          m_nxt     = used_w;
          state_nxt = moepmg_pkg::ST_CLAMP;
        end
      end
      moepmg_pkg::ST_CLAMP: begin
        m_nxt     = m_clamped;
        state_nxt = moepmg_pkg::ST_DROP;
      end
      moepmg_pkg::ST_DROP: begin
        if (m_r < used_w) begin
          drop_nxt = drop_sum[moepmg_pkg::DROP_W] ? '1
                                                  : drop_sum[moepmg_pkg::DROP_W-1:0];
        end
        iss_nxt   = '0;
        ld_nxt    = '0;
        pend_nxt  = 1'b0;
        state_nxt = moepmg_pkg::ST_EMIT;
      end
      moepmg_pkg::ST_EMIT: begin
        rd_en    = (iss_r < m_r) && (!pend_r || can_load);
        pend_nxt = rd_en || (pend_r && !can_load);
        if (rd_en) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (can_load) begin
          load_out = 1'b1;
          ld_nxt   = ld_r + CW'(1);
          if (ld_r == m_r - CW'(1)) begin
            state_nxt = moepmg_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = moepmg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= moepmg_pkg::ST_IDLE;
      seen_r  <= '0;
      pend_r  <= 1'b0;
      drop_r  <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    iss_r  <= iss_nxt;
    ld_r   <= ld_nxt;
    sum_r  <= sum_nxt;
    cum_r  <= cum_nxt;
    prod_r <= prod_nxt;
  end

  // Rank store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rank_mem[wr_addr] <= '{id: in_ch.data.expert_id, prob: in_ch.data.probability};
    end
    if (rd_en) begin
      rd_q <= rank_mem[rd_addr];
    end
  end

  // Output word register: load a kept id, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r.kept_id       <= rd_q.id;
      out_word_r.kept_rank     <= rank_w[moepmg_pkg::RANK_W-1:0];
      out_word_r.last_kept     <= (ld_r == m_r - CW'(1));
      out_word_r.dropped_total <= drop_r;
    end
  end

endmodule

>>> hdl/moepmg_chk.sv
`include "moe_probability_mass_gate_defines.svh"

module moepmg_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_last,
  input logic                  out_valid,
  input logic                  out_ready,
  input moepmg_pkg::out_word_t out_word
);

  `MOEPMG_ASSERT_NXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready, "input ready right after a token's last word")
  `MOEPMG_ASSERT_NOW(a_no_input_mid_stream, out_valid && !out_word.last_kept, !in_ready, "input ready while kept ids still streaming")
  `MOEPMG_ASSERT_NXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "output word withdrawn while stalled")
  `MOEPMG_ASSERT_NXT(a_out_word_hold, out_valid && !out_ready, $stable(out_word), "output word changed while stalled")

endmodule

bind moe_probability_mass_gate moepmg_chk u_moepmg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.data.last_of_token),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.data)
);
